// ----- sv/mbe_pkg.sv -----
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared types and constants for the escape-time block.
// ----------------------------------------------------------------------------
package mbe_pkg;

  localparam int LIMIT_W      = 16;
  localparam int PX_W         = 11;
  localparam int PY_W         = 10;
  localparam int COORD_W      = 12;
  localparam int PX_CENTER    = 1024;
  localparam int PY_CENTER    = 512;
  localparam int COORD_SHIFT  = 9;
  localparam int ESCAPE_SHIFT = 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd1000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_XX,
    ST_MUL_YY,
    ST_MUL_XY,
    ST_UPDATE,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    OP_XX,
    OP_YY,
    OP_XY
  } mul_op_t;

  typedef struct packed {
    logic    load;
    logic    mul_en;
    mul_op_t mul_op;
    logic    upd;
  } ctl_t;

endpackage

// ----- sv/mbe_if.sv -----
// ----------------------------------------------------------------------------
// mbe_if
// Channel interfaces: pixel input, shade result and limit write.
// ----------------------------------------------------------------------------
interface mbe_pix_if import mbe_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PX_W-1:0] pixel_x;
  logic [PY_W-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface mbe_shade_if import mbe_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LIMIT_W-1:0] shade;

  modport source (output valid, output shade, input ready);
  modport sink (input valid, input shade, output ready);
endinterface

interface mbe_cfg_if import mbe_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LIMIT_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/mbe_datapath.sv -----
// ----------------------------------------------------------------------------
// mbe_datapath
// Shared signed multiplier, square/product registers, escape test, z update.
// ----------------------------------------------------------------------------
module mbe_datapath import mbe_pkg::*; #(
  parameter int FRAC_BITS = 28
) (
  input  logic            clk,
  input  ctl_t            ctl,
  input  logic [PX_W-1:0] pixel_x,
  input  logic [PY_W-1:0] pixel_y,
  output logic            escape
);

  localparam int W  = FRAC_BITS + 4;
  localparam int PW = 2 * W;

  localparam logic [PW:0] FOUR = (PW + 1)'(1) << (2 * FRAC_BITS + ESCAPE_SHIFT);

  logic signed [W-1:0]  x_r, y_r, cr_r, ci_r;
  logic signed [PW-1:0] xx_r, yy_r, xy_r;

  logic signed [COORD_W-1:0] dx, dy;
  logic signed [W-1:0]       dx_ext, dy_ext, cr_load, ci_load;
  logic signed [W-1:0]       mul_a, mul_b;
  logic signed [PW-1:0]      prod;
  logic [PW:0]               mag_sum;
  logic signed [PW-1:0]      diff, diff_sh, xy_sh;
  logic signed [W-1:0]       x_nxt, y_nxt;

  always_comb begin
    dx      = signed'({1'b0, pixel_x}) - COORD_W'(PX_CENTER);
    dy      = signed'({2'b00, pixel_y}) - COORD_W'(PY_CENTER);
    dx_ext  = W'(dx);
    dy_ext  = W'(dy);
    cr_load = dx_ext <<< (FRAC_BITS - COORD_SHIFT);
    ci_load = dy_ext <<< (FRAC_BITS - COORD_SHIFT);
  end

  always_comb begin
    case (ctl.mul_op)
      OP_XX: begin
        mul_a = x_r;
        mul_b = x_r;
      end
      OP_YY: begin
        mul_a = y_r;
        mul_b = y_r;
      end
      OP_XY: begin
        mul_a = x_r;
        mul_b = y_r;
      end
      default: begin
        mul_a = x_r;
        mul_b = y_r;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    mag_sum = {xx_r[PW-1], xx_r} + {yy_r[PW-1], yy_r};
    escape  = !mag_sum[PW] && (mag_sum >= FOUR);
    diff    = xx_r - yy_r;
    diff_sh = diff >>> FRAC_BITS;
    xy_sh   = xy_r >>> (FRAC_BITS - 1);
    x_nxt   = diff_sh[W-1:0] + cr_r;
    y_nxt   = xy_sh[W-1:0] + ci_r;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cr_r <= cr_load;
      ci_r <= ci_load;
      x_r  <= '0;
      y_r  <= '0;
    end else if (ctl.upd) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
    end
    if (ctl.mul_en) begin
      case (ctl.mul_op)
        OP_XX:   xx_r <= prod;
        OP_YY:   yy_r <= prod;
        OP_XY:   xy_r <= prod;
        default: xy_r <= prod;
      endcase
    end
  end

endmodule

// ----- sv/mbe_ctrl.sv -----
// ----------------------------------------------------------------------------
// mbe_ctrl
// Iteration sequencer, step counter and result beat.
// ----------------------------------------------------------------------------
module mbe_ctrl import mbe_pkg::*; #(
  parameter int ITER_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  logic [LIMIT_W-1:0] limit,
  input  logic               escape,
  output ctl_t               ctl,
  output logic [LIMIT_W-1:0] shade
);

  localparam int CW = (ITER_WIDTH > LIMIT_W) ? ITER_WIDTH : LIMIT_W;

  state_t                state_r, state_nxt;
  logic [ITER_WIDTH-1:0] steps_r, steps_nxt, steps_inc, limit_eff;
  logic [CW-1:0]         lim_ext, cnt_max_ext;

  always_comb begin
    lim_ext     = CW'(limit);
    cnt_max_ext = CW'({ITER_WIDTH{1'b1}});
    limit_eff   = (lim_ext > cnt_max_ext) ? ITER_WIDTH'(cnt_max_ext) : ITER_WIDTH'(lim_ext);
    steps_inc   = steps_r + ITER_WIDTH'(1);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (limit_eff == '0) ? ST_DONE : ST_MUL_XX;
        end
      end
      ST_MUL_XX: state_nxt = ST_MUL_YY;
      ST_MUL_YY: state_nxt = ST_MUL_XY;
      ST_MUL_XY: state_nxt = escape ? ST_DONE : ST_UPDATE;
      ST_UPDATE: state_nxt = (steps_inc >= limit_eff) ? ST_DONE : ST_MUL_XX;
      ST_DONE: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl       = '{load: 1'b0, mul_en: 1'b0, mul_op: OP_XX, upd: 1'b0};
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        ctl.load = in_valid;
      end
      ST_MUL_XX: begin
        ctl.mul_en = 1'b1;
        ctl.mul_op = OP_XX;
      end
      ST_MUL_YY: begin
        ctl.mul_en = 1'b1;
        ctl.mul_op = OP_YY;
      end
      ST_MUL_XY: begin
        ctl.mul_en = 1'b1;
        ctl.mul_op = OP_XY;
      end
      ST_UPDATE: ctl.upd = 1'b1;
      ST_DONE:   out_valid = 1'b1;
      default:   in_ready = 1'b0;
    endcase
  end

  always_comb begin
    steps_nxt = steps_r;
    if (ctl.load) begin
      steps_nxt = '0;
    end else if (ctl.upd) begin
      steps_nxt = steps_inc;
    end
  end

  assign shade = limit - LIMIT_W'(steps_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      steps_r <= '0;
    end else begin
      state_r <= state_nxt;
      steps_r <= steps_nxt;
    end
  end

  a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (steps_r <= limit_eff))
    else $error("step count above limit");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready while pixel in flight");

  a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |=> (state_r == ST_IDLE))
    else $error("no return to idle after result beat");

  a_update_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPDATE) |-> ($past(state_r) == ST_MUL_XY && !$past(escape)))
    else $error("z update without full non-escaping step");

endmodule

// ----- sv/mandelbrot_escape_time.sv -----
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// Escape-time count for one pixel, Q4.FRAC_BITS fixed point, one shared
// multiplier under an iteration sequencer.
// ----------------------------------------------------------------------------
//  channel   dir  payload            beat when
//  in_pix    in   pixel_x, pixel_y   valid && ready
//  out_res   out  shade              valid && ready
//  cfg_wr    in   data (limit)       valid && ready
//
//  Each iteration runs in four states: three passes through the shared multiplier
//  (x*x, y*y, x*y) and one z update; the escape test runs in the x*y state.
//  A pixel runs n steps (at most the limit) up to its result beat, whether or
//  not it escapes; the result holds until taken.
//  Reset sets the limit to 1000 and the sequencer to idle.
//  in_pix.ready is high only while idle; cfg_wr is always ready.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time import mbe_pkg::*; #(
  parameter int FRAC_BITS  = 28,
  parameter int ITER_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  mbe_pix_if.sink   in_pix,
  mbe_shade_if.source out_res,
  mbe_cfg_if.sink   cfg_wr
);

  logic [LIMIT_W-1:0] limit_r, limit_nxt;
  ctl_t               ctl;
  logic               escape;

  assign cfg_wr.ready = 1'b1;
  assign limit_nxt    = (cfg_wr.valid && cfg_wr.ready) ? cfg_wr.data : limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else begin
      limit_r <= limit_nxt;
    end
  end

  mbe_ctrl #(
    .ITER_WIDTH(ITER_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_pix.valid),
    .in_ready (in_pix.ready),
    .out_valid(out_res.valid),
    .out_ready(out_res.ready),
    .limit    (limit_r),
    .escape   (escape),
    .ctl      (ctl),
    .shade    (out_res.shade)
  );

  mbe_datapath #(
    .FRAC_BITS(FRAC_BITS)
  ) u_datapath (
    .clk    (clk),
    .ctl    (ctl),
    .pixel_x(in_pix.pixel_x),
    .pixel_y(in_pix.pixel_y),
    .escape (escape)
  );

endmodule

// ----- tb/mandelbrot_escape_time_tb.sv -----
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_tb
// Drives pixel beats and limit writes into the escape-time block, predicts
// each shade with a full-width fixed-point iteration of z = z*z + c, and
// checks every result beat in order. Limits sweep from zero to full scale,
// with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mandelbrot_escape_time_tb import mbe_pkg::*; ();

  localparam int FRAC = 28;

  class shade_scoreboard;
    logic [LIMIT_W-1:0] limit;
    logic [LIMIT_W-1:0] expected_shades[$];
    int unsigned errors;
    int unsigned pixels;
    int unsigned shades;
    int unsigned limit_writes;

    function new();
      limit = LIMIT_RESET;
    endfunction

    function void set_limit(logic [LIMIT_W-1:0] value);
      limit = value;
      limit_writes++;
    endfunction

    function logic [LIMIT_W-1:0] escape_shade(logic [PX_W-1:0] px, logic [PY_W-1:0] py);
      longint cr, ci, re, im, re_next;
      logic signed [127:0] rr, ii, ri, four;
      int unsigned steps;
      cr = (longint'(px) - PX_CENTER) <<< (FRAC - COORD_SHIFT);
      ci = (longint'(py) - PY_CENTER) <<< (FRAC - COORD_SHIFT);
      four = 128'sd4 <<< (2 * FRAC);
      re = 0;
      im = 0;
      steps = 0;
      while (steps < limit) begin
        rr = re * re;
        ii = im * im;
        if (rr + ii >= four) break;
        ri = re * im;
        re_next = longint'((rr - ii) >>> FRAC) + cr;
        im = longint'(ri >>> (FRAC - 1)) + ci;
        re = re_next;
        steps++;
      end
      return LIMIT_W'(limit - steps);
    endfunction

    function void note_pixel(logic [PX_W-1:0] px, logic [PY_W-1:0] py);
      expected_shades.push_back(escape_shade(px, py));
      pixels++;
    endfunction

    function void check_shade(logic [LIMIT_W-1:0] got);
      logic [LIMIT_W-1:0] want;
      shades++;
      if (expected_shades.size() == 0) begin
        errors++;
        $display("%0t: shade beat with nothing pending, actual %0d", $time, got);
      end else begin
        want = expected_shades.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: shade mismatch, expected %0d actual %0d", $time, want, got);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_shades.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bit src_gaps = 1'b0;
  bit sink_stalls = 1'b0;
  int unsigned ready_hold = 0;

  mbe_pix_if   pix();
  mbe_shade_if res();
  mbe_cfg_if   cfg();

  shade_scoreboard sb = new();

  mandelbrot_escape_time #(
    .FRAC_BITS (FRAC),
    .ITER_WIDTH(16)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_pix (pix),
    .out_res(res),
    .cfg_wr (cfg)
  );

  always #10 clk = ~clk;

  function automatic int unsigned random_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(12, 40);
    return $urandom_range(0, 2);
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg.valid && cfg.ready) sb.set_limit(cfg.data);
      if (res.valid && res.ready) sb.check_shade(res.shade);
      if (pix.valid && pix.ready) sb.note_pixel(pix.pixel_x, pix.pixel_y);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      res.ready <= 1'b0;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (!sink_stalls || $urandom_range(0, 2) != 0) begin
      res.ready <= 1'b1;
      ready_hold <= $urandom_range(0, 6);
    end else begin
      res.ready <= 1'b0;
      ready_hold <= random_gap();
    end
  end

  task automatic send_pixel(input int unsigned px, input int unsigned py);
    int unsigned gap;
    pix.valid <= 1'b1;
    pix.pixel_x <= PX_W'(px);
    pix.pixel_y <= PY_W'(py);
    do @(posedge clk); while (!pix.ready);
    gap = src_gaps ? random_gap() : 0;
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drop valid and hold until every shade has come back
  task automatic wait_idle();
    pix.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    wait_idle();
    cfg.valid <= 1'b1;
    cfg.data <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
  endtask

  task automatic send_random_pixel();
    if ($urandom_range(0, 9) < 7)
      send_pixel($urandom_range(0, 1280), $urandom_range(0, 1023));
    else
      send_pixel($urandom_range(0, 2047), $urandom_range(0, 1023));
  endtask

  task automatic run_limit_phase(input logic [LIMIT_W-1:0] value, input int count,
                                 input bit gaps);
    write_limit(value);
    src_gaps = gaps;
    sink_stalls = gaps;
    repeat (count) send_random_pixel();
  endtask

  initial begin
    pix.valid = 1'b0;
    pix.pixel_x = '0;
    pix.pixel_y = '0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset limit, field extremes and landmark points
    send_pixel(0, 0);
    send_pixel(2047, 1023);
    send_pixel(0, 1023);
    send_pixel(2047, 0);
    send_pixel(1024, 512);
    send_pixel(0, 512);
    send_pixel(512, 512);
    send_pixel(1024, 0);
    send_pixel(1024, 1023);
    send_pixel(1152, 512);
    send_pixel(1153, 512);
    send_pixel(768, 768);
    send_pixel(1023, 511);

    write_limit('0);
    send_pixel(1024, 512);
    send_pixel(2047, 1023);
    send_pixel(0, 0);

    write_limit('1);
    send_pixel(1024, 512);
    send_pixel(0, 512);
    send_pixel(1153, 512);
    send_pixel(2047, 0);

    write_limit(16'd1);
    send_pixel(1024, 512);
    send_pixel(0, 512);
    send_pixel(2047, 1023);

    run_limit_phase(16'd2, 60, 1'b1);
    run_limit_phase(16'd5, 60, 1'b0);
    run_limit_phase(16'd16, 80, 1'b1);
    run_limit_phase(16'd40, 40, 1'b1);
    wait_idle();
    repeat (40) send_random_pixel();
    run_limit_phase(16'd100, 70, 1'b0);
    run_limit_phase(LIMIT_W'($urandom_range(1, 64)), 80, 1'b1);
    run_limit_phase(16'd255, 60, 1'b1);
    run_limit_phase('0, 20, 1'b1);
    run_limit_phase(16'd1, 40, 1'b1);
    run_limit_phase(LIMIT_RESET, 12, 1'b1);

    wait_idle();
    repeat (8) @(posedge clk);
    if (sb.pending() != 0) sb.errors++;
    $display("covered %0d pixels and %0d shade beats over %0d limit writes",
             sb.pixels, sb.shades, sb.limit_writes);
    $display("limits ran from 0 to 65535 with random gaps and stalls on both channels");
    if (sb.errors == 0)
      $display("mandelbrot_escape_time_tb passed");
    else
      $display("mandelbrot_escape_time_tb failed");
    $finish;
  end

  initial begin
    #100ms;
    $display("mandelbrot_escape_time_tb failed");
    $finish;
  end

endmodule

// ----- mandelbrot_escape_time.f -----
sv/mbe_pkg.sv
sv/mbe_if.sv
sv/mbe_datapath.sv
sv/mbe_ctrl.sv
sv/mandelbrot_escape_time.sv
tb/mandelbrot_escape_time_tb.sv
